### hdl/sgi_pkg.sv
// Package for the segment intersection unit.
// Holds the item types, result kind codes and default sizes; no dependencies.
`default_nettype none

package sgi_pkg;

    localparam int SGI_FIELD_W  = 16;
    localparam int SGI_POINT_W  = 24;
    localparam int SGI_COORD_W  = 16;
    localparam int SGI_FRAC_W   = 8;

    typedef enum logic [1:0] {
        KIND_CROSS      = 2'd0,
        KIND_PARALLEL   = 2'd1,
        KIND_COINCIDENT = 2'd2,
        KIND_OUTSIDE    = 2'd3
    } t_kind;

    typedef struct packed {
        logic signed [SGI_FIELD_W-1:0] a_start_x;
        logic signed [SGI_FIELD_W-1:0] a_start_y;
        logic signed [SGI_FIELD_W-1:0] a_end_x;
        logic signed [SGI_FIELD_W-1:0] a_end_y;
        logic signed [SGI_FIELD_W-1:0] b_start_x;
        logic signed [SGI_FIELD_W-1:0] b_start_y;
        logic signed [SGI_FIELD_W-1:0] b_end_x;
        logic signed [SGI_FIELD_W-1:0] b_end_y;
    } t_sgi_in;

    typedef struct packed {
        logic                          hit;
        logic [1:0]                    kind;
        logic signed [SGI_POINT_W-1:0] point_x;
        logic signed [SGI_POINT_W-1:0] point_y;
    } t_sgi_out;

    // Control that travels beside the divider stages.
    typedef struct packed {
        logic  valid;
        logic  hit;
        t_kind kind;
        logic  neg_x;
        logic  neg_y;
    } t_sgi_side;

endpackage

`default_nettype wire

### hdl/sgi_front.sv
// Geometry front end: differences, cross products, classification and
// the point numerators, five register stages. Depends on sgi_pkg.
`default_nettype none

module sgi_front
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = SGI_COORD_W,
    localparam int CW = (COORD_WIDTH < SGI_FIELD_W) ? COORD_WIDTH : SGI_FIELD_W,
    localparam int DW = CW + 1,
    localparam int PW = 2 * DW + 1,
    localparam int NW = PW + DW + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire t_sgi_in       i_data,
    output t_sgi_side          o_side,
    output logic [NW-1:0]      o_mag_nx,
    output logic [NW-1:0]      o_mag_ny,
    output logic [PW-1:0]      o_mag_d
);

    logic signed [DW-1:0] w_asx, w_asy, w_aex, w_aey, w_bsx, w_bsy, w_bex, w_bey;

    assign w_asx = $signed({i_data.a_start_x[CW-1], i_data.a_start_x[CW-1:0]});
    assign w_asy = $signed({i_data.a_start_y[CW-1], i_data.a_start_y[CW-1:0]});
    assign w_aex = $signed({i_data.a_end_x[CW-1], i_data.a_end_x[CW-1:0]});
    assign w_aey = $signed({i_data.a_end_y[CW-1], i_data.a_end_y[CW-1:0]});
    assign w_bsx = $signed({i_data.b_start_x[CW-1], i_data.b_start_x[CW-1:0]});
    assign w_bsy = $signed({i_data.b_start_y[CW-1], i_data.b_start_y[CW-1:0]});
    assign w_bex = $signed({i_data.b_end_x[CW-1], i_data.b_end_x[CW-1:0]});
    assign w_bey = $signed({i_data.b_end_y[CW-1], i_data.b_end_y[CW-1:0]});

    // Stage 1: differences.
    logic                 r_v1;
    logic signed [DW-1:0] r_dax, r_day, r_dbx, r_dby, r_ox, r_oy;
    logic signed [CW-1:0] r_bsx1, r_bsy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_dax  <= DW'(w_aex - w_asx);
            r_day  <= DW'(w_aey - w_asy);
            r_dbx  <= DW'(w_bex - w_bsx);
            r_dby  <= DW'(w_bey - w_bsy);
            r_ox   <= DW'(w_bsx - w_asx);
            r_oy   <= DW'(w_bsy - w_asy);
            r_bsx1 <= w_bsx[CW-1:0];
            r_bsy1 <= w_bsy[CW-1:0];
        end
    end

    // Stage 2: the six cross-product terms.
    logic                   r_v2;
    logic signed [2*DW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DW-1:0]   r_dbx2, r_dby2;
    logic signed [CW-1:0]   r_bsx2, r_bsy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_p0   <= r_day * r_dbx;
            r_p1   <= r_dax * r_dby;
            r_p2   <= r_dax * r_oy;
            r_p3   <= r_day * r_ox;
            r_p4   <= r_dbx * r_oy;
            r_p5   <= r_dby * r_ox;
            r_dbx2 <= r_dbx;
            r_dby2 <= r_dby;
            r_bsx2 <= r_bsx1;
            r_bsy2 <= r_bsy1;
        end
    end

    // Stage 3: denominator and the two numerators.
    logic                 r_v3;
    logic signed [PW-1:0] r_den, r_nt, r_nu;
    logic signed [DW-1:0] r_dbx3, r_dby3;
    logic signed [CW-1:0] r_bsx3, r_bsy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_den  <= PW'(r_p0) - PW'(r_p1);
            r_nt   <= PW'(r_p2) - PW'(r_p3);
            r_nu   <= PW'(r_p4) - PW'(r_p5);
            r_dbx3 <= r_dbx2;
            r_dby3 <= r_dby2;
            r_bsx3 <= r_bsx2;
            r_bsy3 <= r_bsy2;
        end
    end

    // Stage 4: classification, and the point numerator terms.
    logic  w_den_zero, w_in_t, w_in_u;
    t_kind w_kind;

    always_comb begin
        w_den_zero = (r_den == '0);
        if (!r_den[PW-1]) begin
            w_in_t = !r_nt[PW-1] && (r_nt <= r_den);
            w_in_u = !r_nu[PW-1] && (r_nu <= r_den);
        end else begin
            w_in_t = (r_nt <= 0) && (r_nt >= r_den);
            w_in_u = (r_nu <= 0) && (r_nu >= r_den);
        end
        if (w_den_zero) begin
            w_kind = (r_nt == '0 && r_nu == '0) ? KIND_COINCIDENT : KIND_PARALLEL;
        end else if (!w_in_t || !w_in_u) begin
            w_kind = KIND_OUTSIDE;
        end else begin
            w_kind = KIND_CROSS;
        end
    end

    logic                    r_v4;
    t_kind                   r_kind4;
    logic signed [CW+PW-1:0] r_pbx, r_pby;
    logic signed [PW+DW-1:0] r_ptx, r_pty;
    logic signed [PW-1:0]    r_den4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_kind4 <= w_kind;
            r_pbx   <= r_bsx3 * r_den;
            r_pby   <= r_bsy3 * r_den;
            r_ptx   <= r_nt * r_dbx3;
            r_pty   <= r_nt * r_dby3;
            r_den4  <= r_den;
        end
    end

    // Stage 5: full numerators, then sign and magnitude for the dividers.
    logic signed [NW-1:0] w_nx, w_ny, w_pbx_e, w_pby_e, w_ptx_e, w_pty_e;

    assign w_pbx_e = NW'(r_pbx);
    assign w_pby_e = NW'(r_pby);
    assign w_ptx_e = NW'(r_ptx);
    assign w_pty_e = NW'(r_pty);
    assign w_nx    = w_pbx_e + w_ptx_e;
    assign w_ny    = w_pby_e + w_pty_e;

    t_sgi_side r_side;
    logic [NW-1:0] r_mag_nx, r_mag_ny;
    logic [PW-1:0] r_mag_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= r_v4;
        end
        if (i_en) begin
            r_side.hit   <= (r_kind4 == KIND_CROSS);
            r_side.kind  <= r_kind4;
            r_side.neg_x <= w_nx[NW-1] ^ r_den4[PW-1];
            r_side.neg_y <= w_ny[NW-1] ^ r_den4[PW-1];
            r_mag_nx     <= w_nx[NW-1] ? NW'(~w_nx + 1'b1) : NW'(w_nx);
            r_mag_ny     <= w_ny[NW-1] ? NW'(~w_ny + 1'b1) : NW'(w_ny);
            r_mag_d      <= r_den4[PW-1] ? PW'(~r_den4 + 1'b1) : PW'(r_den4);
        end
    end

    assign o_side   = r_side;
    assign o_mag_nx = r_mag_nx;
    assign o_mag_ny = r_mag_ny;
    assign o_mag_d  = r_mag_d;

endmodule

`default_nettype wire

### hdl/sgi_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Gives floor(num * 2^(QW-SW) / den) for a quotient known to fit QW bits.
// Depends on sgi_pkg.
`default_nettype none

module sgi_div
    import sgi_pkg::*;
#(
    parameter int NW = 36,
    parameter int PW = 35,
    parameter int SW = 16,
    parameter int QW = 25
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [PW-1:0] i_den,
    output logic [QW-1:0]      o_quot
);

    // Each stage holds the partial remainder and one shared word whose
    // upper part still holds dividend bits and whose lower part collects
    // quotient bits.
    logic [PW-1:0] r_rem [QW];
    logic [QW-1:0] r_acc [QW];
    logic [PW-1:0] r_den [QW];

    logic [PW-1:0] w_rem_in [QW];
    logic [QW-1:0] w_acc_in [QW];
    logic [PW-1:0] w_den_in [QW];

    assign w_rem_in[0] = PW'(i_num >> SW);
    assign w_acc_in[0] = {i_num[SW-1:0], {(QW-SW){1'b0}}};
    assign w_den_in[0] = i_den;

    for (genvar k = 1; k < QW; k++) begin : g_link
        assign w_rem_in[k] = r_rem[k-1];
        assign w_acc_in[k] = r_acc[k-1];
        assign w_den_in[k] = r_den[k-1];
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [PW:0] w_trial;
        logic [PW:0] w_diff;
        logic        w_ge;

        assign w_trial = {w_rem_in[k], w_acc_in[k][QW-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den_in[k]});
        assign w_diff  = w_trial - {1'b0, w_den_in[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_diff[PW-1:0] : w_trial[PW-1:0];
                r_acc[k] <= {w_acc_in[k][QW-2:0], w_ge};
                r_den[k] <= w_den_in[k];
            end
        end
    end

    assign o_quot = r_acc[QW-1];

endmodule

`default_nettype wire

### hdl/segment_intersection_unit.sv
// Segment intersection unit, top level: front end, two dividers, rounding.
// Depends on sgi_pkg, sgi_front and sgi_div.
//
// Takes one pair of segments per cycle and gives one result item per input
// item, in order. The pipeline is five front-end stages for the cross
// products and classification, one stage per quotient bit in each point
// divider, and the output register. A stalled output holds the whole
// pipeline; the input is still taken while the output register is empty
// or draining.
`default_nettype none

module segment_intersection_unit
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = SGI_COORD_W,
    parameter int FRAC_BITS   = SGI_FRAC_W
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_sgi_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_sgi_out      o_out_data
);

    localparam int CW = (COORD_WIDTH < SGI_FIELD_W) ? COORD_WIDTH : SGI_FIELD_W;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW + 1;
    localparam int NW = PW + DW + 1;
    localparam int QW = CW + FRAC_BITS + 1;
    localparam int MW = (QW + 1 > SGI_POINT_W) ? QW + 1 : SGI_POINT_W;

    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    t_sgi_side     w_side;
    logic [NW-1:0] w_mag_nx, w_mag_ny;
    logic [PW-1:0] w_mag_d;

    sgi_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .o_side   (w_side),
        .o_mag_nx (w_mag_nx),
        .o_mag_ny (w_mag_ny),
        .o_mag_d  (w_mag_d)
    );

    logic [QW-1:0] w_qx, w_qy;

    sgi_div #(.NW(NW), .PW(PW), .SW(CW), .QW(QW)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_mag_nx),
        .i_den  (w_mag_d),
        .o_quot (w_qx)
    );

    sgi_div #(.NW(NW), .PW(PW), .SW(CW), .QW(QW)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_mag_ny),
        .i_den  (w_mag_d),
        .o_quot (w_qy)
    );

    // Side information moves in step with the divider stages.
    t_sgi_side r_side [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_en) begin
            r_side[0].valid <= w_side.valid;
            for (int k = 1; k < QW; k++) begin
                r_side[k].valid <= r_side[k-1].valid;
            end
        end
        if (w_en) begin
            r_side[0].hit   <= w_side.hit;
            r_side[0].kind  <= w_side.kind;
            r_side[0].neg_x <= w_side.neg_x;
            r_side[0].neg_y <= w_side.neg_y;
            for (int k = 1; k < QW; k++) begin
                r_side[k].hit   <= r_side[k-1].hit;
                r_side[k].kind  <= r_side[k-1].kind;
                r_side[k].neg_x <= r_side[k-1].neg_x;
                r_side[k].neg_y <= r_side[k-1].neg_y;
            end
        end
    end

    // The quotient carries one extra fraction bit; adding one and dropping
    // it rounds to nearest with ties away from zero on the magnitude.
    logic [QW:0]   w_rx, w_ry;
    logic [MW-1:0] w_mx, w_my, w_sx, w_sy;
    t_sgi_side     w_last;

    assign w_last = r_side[QW-1];
    assign w_rx   = ({1'b0, w_qx} + 1'b1) >> 1;
    assign w_ry   = ({1'b0, w_qy} + 1'b1) >> 1;
    assign w_mx   = MW'(w_rx);
    assign w_my   = MW'(w_ry);
    assign w_sx   = w_last.neg_x ? (~w_mx + 1'b1) : w_mx;
    assign w_sy   = w_last.neg_y ? (~w_my + 1'b1) : w_my;

    t_sgi_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
        if (w_en) begin
            r_out.hit     <= w_last.hit;
            r_out.kind    <= w_last.kind;
            r_out.point_x <= w_last.hit ? w_sx[SGI_POINT_W-1:0] : '0;
            r_out.point_y <= w_last.hit ? w_sy[SGI_POINT_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### hdl/sgi_checker.sv
// Port-level checks for the segment intersection unit, bound to the top.
// Depends on sgi_pkg.
`default_nettype none

module sgi_checker
    import sgi_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_in_ready,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_sgi_out o_out_data
);

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result item changed or dropped");

    a_hit_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.hit == (o_out_data.kind == KIND_CROSS)))
        else $error("hit flag disagrees with kind");

    a_point_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |->
            (o_out_data.point_x == '0) && (o_out_data.point_y == '0))
        else $error("nonzero point without a hit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

endmodule

bind segment_intersection_unit sgi_checker u_sgi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

### verif/tb_segment_intersection_unit.sv
// Testbench for segment_intersection_unit: directed and random segment pairs,
// with an exact integer predictor of the result kind and the rounded point.
// Depends on sgi_pkg and the RTL of segment_intersection_unit.
`timescale 1ns / 100ps

class sgi_scoreboard;
    sgi_pkg::t_sgi_out pending_q[$];
    int                n_errors;

    function automatic logic [23:0] round_point(longint num, longint den);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] sr;
        logic [63:0] m;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q  = an / ad;
        r  = an % ad;
        sr = r << sgi_pkg::SGI_FRAC_W;
        m  = (q << sgi_pkg::SGI_FRAC_W) + sr / ad;
        if ((sr % ad) * 2 >= ad) m = m + 1;
        if ((num < 0) != (den < 0)) m = -m;
        return m[23:0];
    endfunction

    function automatic bit in_range(longint num, longint den);
        if (den > 0) return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    // Works out the result that one accepted pair of segments must give.
    function void note_input(sgi_pkg::t_sgi_in s);
        sgi_pkg::t_sgi_out e;
        longint dax, day, dbx, dby, ox, oy, den, nt, nu;
        dax = longint'(s.a_end_x) - s.a_start_x;
        day = longint'(s.a_end_y) - s.a_start_y;
        dbx = longint'(s.b_end_x) - s.b_start_x;
        dby = longint'(s.b_end_y) - s.b_start_y;
        ox  = longint'(s.b_start_x) - s.a_start_x;
        oy  = longint'(s.b_start_y) - s.a_start_y;
        den = day * dbx - dax * dby;
        nt  = dax * oy - day * ox;
        nu  = dbx * oy - dby * ox;
        e = '0;
        if (den == 0) begin
            e.kind = (nt == 0 && nu == 0) ? sgi_pkg::KIND_COINCIDENT : sgi_pkg::KIND_PARALLEL;
        end else if (!in_range(nt, den) || !in_range(nu, den)) begin
            e.kind = sgi_pkg::KIND_OUTSIDE;
        end else begin
            e.hit     = 1'b1;
            e.kind    = sgi_pkg::KIND_CROSS;
            e.point_x = round_point(longint'(s.b_start_x) * den + nt * dbx, den);
            e.point_y = round_point(longint'(s.b_start_y) * den + nt * dby, den);
        end
        pending_q.push_back(e);
    endfunction

    function void check_result(sgi_pkg::t_sgi_out got);
        sgi_pkg::t_sgi_out e;
        if (pending_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10) $display("unexpected result item %p", got);
            return;
        end
        e = pending_q.pop_front();
        if (got.hit !== e.hit || got.kind !== e.kind || got.point_x !== e.point_x
            || got.point_y !== e.point_y) begin
            n_errors++;
            if (n_errors <= 10) $display("mismatch: expected %p, got %p", e, got);
        end
    endfunction
endclass

module tb_segment_intersection_unit;
    import sgi_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    t_sgi_in  in_data;
    logic     out_valid;
    logic     out_ready;
    t_sgi_out out_data;

    sgi_scoreboard board;
    bit            stim_done;

    segment_intersection_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($signed($urandom_range(0, 200)) - 100);
        if (r < 6) return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    // Valid stays high between back-to-back items; it drops only for a gap.
    task automatic send(t_sgi_in s, bit allow_gap);
        int gap;
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_input(s);
    endtask

    task automatic send_seg(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1);
        t_sgi_in s;
        s = '{16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1),
              16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
        send(s, 1'b0);
    endtask

    // Builds a pair that crosses inside both segments most of the time.
    function automatic t_sgi_in crossing_pair();
        t_sgi_in s;
        int cx, cy, span;
        span = ($urandom_range(0, 3) == 0) ? 16000 : 300;
        cx = $signed($urandom_range(0, 2 * span)) - span;
        cy = $signed($urandom_range(0, 2 * span)) - span;
        s.a_start_x = 16'(cx - $signed($urandom_range(0, span)));
        s.a_start_y = 16'(cy - $signed($urandom_range(0, span)));
        s.a_end_x   = 16'(cx + $signed($urandom_range(0, span)));
        s.a_end_y   = 16'(cy + $signed($urandom_range(0, span)));
        s.b_start_x = 16'(cx + $signed($urandom_range(0, span)));
        s.b_start_y = 16'(cy - $signed($urandom_range(0, span)));
        s.b_end_x   = 16'(cx - $signed($urandom_range(0, span)));
        s.b_end_y   = 16'(cy + $signed($urandom_range(0, span)));
        return s;
    endfunction

    initial begin
        t_sgi_in s;
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        stim_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Crossing, touching at ends, parallel, coincident, outside.
        send_seg(0, 0, 10, 10, 0, 10, 10, 0);
        send_seg(0, 0, 4, 0, 4, 0, 4, 5);
        send_seg(0, 0, 10, 0, 0, 1, 10, 1);
        send_seg(0, 0, 10, 0, 2, 0, 7, 0);
        send_seg(0, 0, 1, 1, 5, 0, 6, -2);
        send_seg(3, 3, 3, 3, 3, 3, 3, 3);
        send_seg(0, 0, 3, 0, 1, 1, 2, -2);
        send_seg(0, 0, 3, 1, 1, 5, 2, -5);
        send_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_seg(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_seg(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        send_seg(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
        send_seg(0, 0, 7, 3, 1, 5, 1, -5);
        send_seg(0, 0, -7, 3, -1, 5, -1, -5);
        send_seg(0, 0, 3, 0, 0, 0, 0, 3);
        send_seg(0, 0, 1, 0, 2, 0, 3, 0);

        for (int i = 0; i < 800; i++) begin
            if (i == 400) begin
                // Hold off until the pipeline has drained completely.
                in_valid <= 1'b0;
                while (board.pending_q.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                s = crossing_pair();
            end else begin
                s = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
            end
            send(s, ($urandom_range(0, 3) == 0) || (i > 600));
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int hold;
        out_ready = 1'b0;
        hold      = 0;
        @(posedge rst_n);
        forever begin
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else if ($urandom_range(0, 19) == 0) begin
                out_ready <= 1'b0;
                hold = pick_gap();
            end else begin
                out_ready <= ($urandom_range(0, 9) < 8);
            end
            @(posedge clk);
            if (out_valid && out_ready) board.check_result(out_data);
        end
    end

    initial begin
        @(posedge stim_done);
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (board.n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
